>>> rtl/core/gtd_pkg.sv
// Shared types, constants and helper functions of the gang task dispatcher.
`timescale 1ns / 1ps
`default_nettype none

package gtd_pkg;

    localparam int DEF_TASK_SLOTS     = 16;
    localparam int DEF_MAX_SUBTASKS   = 32;
    localparam int DEF_MAX_PROCESSORS = 64;
    localparam int CMD_QUEUE_DEPTH    = 2;
    localparam int RES_QUEUE_DEPTH    = 2;

    localparam int PROC_W = 7;
    localparam int DUR_W  = 16;
    localparam int STAT_W = 32;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RING_FULL = 2'd1;
    localparam logic [1:0] ST_TOO_MANY  = 2'd2;
    localparam logic [1:0] ST_ZERO_DUR  = 2'd3;

    typedef enum logic {
        K_LOAD = 1'b0,
        K_TICK = 1'b1
    } t_kind;

    typedef struct packed {
        logic             operation;
        logic             priority_req;
        logic [DUR_W-1:0] duration;
        logic             last_subtask;
    } t_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [PROC_W-1:0] busy_processors;
        logic [5:0]        tasks_present;
        logic [5:0]        retired_count;
        logic [STAT_W-1:0] retired_resident_sum;
        logic [STAT_W-1:0] retired_service_sum;
        logic [STAT_W-1:0] max_service;
    } t_result;

    typedef struct packed {
        t_kind            kind;
        logic             pri;
        logic [DUR_W-1:0] dur;
        logic             last;
        logic             zero_dur;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_ALLOC,
        S_SLOT_CHK,
        S_SUB_RD,
        S_SUB_WR,
        S_SLOT_END,
        S_RECLAIM,
        S_FINISH
    } t_state;

    function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] a);
        return (a == {STAT_W{1'b1}}) ? a : a + STAT_W'(1);
    endfunction

    function automatic logic [STAT_W-1:0] sat_add(input logic [STAT_W-1:0] a,
                                                  input logic [STAT_W-1:0] b);
        logic [STAT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[STAT_W] ? {STAT_W{1'b1}} : s[STAT_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/gtd_fifo.sv
// Small register queue used between the front, the back and the result port.
`timescale 1ns / 1ps
`default_nettype none

module gtd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/gtd_front.sv
// Front end: takes input words, classifies them and queues commands for the back end.
`timescale 1ns / 1ps
`default_nettype none

module gtd_front
    import gtd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_cmd_pop,
    output t_cmd       o_cmd,
    output logic       o_cmd_empty
);

    t_cmd                   cmd_in;
    logic [$bits(t_cmd)-1:0] cmd_bits;

    always_comb begin
        cmd_in.kind     = i_item.operation ? K_TICK : K_LOAD;
        cmd_in.pri      = i_item.priority_req;
        cmd_in.dur      = i_item.duration;
        cmd_in.last     = i_item.last_subtask;
        // Zero duration is flagged here so the back end only checks one bit.
        cmd_in.zero_dur = (i_item.duration == '0);
    end

    gtd_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cmd_in),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (cmd_bits),
        .o_empty (o_cmd_empty)
    );

    assign o_cmd = t_cmd'(cmd_bits);

endmodule

`default_nettype wire

>>> rtl/core/gtd_back.sv
// Back end: task table, subtask memory and the sequencer that runs loads and ticks.
`timescale 1ns / 1ps
`default_nettype none

module gtd_back
    import gtd_pkg::*;
#(
    parameter int TASK_SLOTS     = DEF_TASK_SLOTS,
    parameter int MAX_SUBTASKS   = DEF_MAX_SUBTASKS,
    parameter int MAX_PROCESSORS = DEF_MAX_PROCESSORS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    input  wire logic [PROC_W-1:0] i_cfg_data,
    input  wire t_cmd              i_cmd,
    input  wire logic              i_cmd_empty,
    output logic                   o_cmd_pop,
    input  wire logic              i_res_full,
    output logic                   o_res_push,
    output t_result                o_result
);

    localparam int NS     = 2 * TASK_SLOTS;
    localparam int SLOT_W = $clog2(NS);
    localparam int IDX_W  = $clog2(TASK_SLOTS);
    localparam int POS_W  = $clog2(TASK_SLOTS + 1);
    localparam int SUM_W  = IDX_W + 1;
    localparam int CNT_W  = $clog2(MAX_SUBTASKS + 1);
    localparam int K_W    = (MAX_SUBTASKS > 1) ? $clog2(MAX_SUBTASKS) : 1;
    localparam int NSUB   = NS * MAX_SUBTASKS;
    localparam int ADDR_W = $clog2(NSUB);
    localparam int PRES_W = $clog2(NS + 1);

    t_state r_state, n_state;
    t_cmd   r_cmd, n_cmd;

    logic [NS-1:0]     r_valid, n_valid, r_started, n_started;
    logic [CNT_W-1:0]  r_cnt [NS], n_cnt [NS], r_done [NS], n_done [NS];
    logic [STAT_W-1:0] r_res [NS], n_res [NS], r_svc [NS], n_svc [NS];

    logic [IDX_W-1:0]  r_head_idx [2], n_head_idx [2], r_tail_idx [2], n_tail_idx [2];
    logic [1:0]        r_head_wrap, n_head_wrap, r_tail_wrap, n_tail_wrap;

    logic [PROC_W-1:0] r_free, n_free, r_pool, n_pool, r_busy, n_busy;
    logic [CNT_W-1:0]  r_load_idx, n_load_idx;
    logic              r_load_pri, n_load_pri;
    logic [STAT_W-1:0] r_max, n_max, r_rres, n_rres, r_rsvc, n_rsvc;
    logic [PRES_W-1:0] r_present, n_present, r_pres_snap, n_pres_snap;
    logic [PRES_W-1:0] r_rcount, n_rcount;
    logic [1:0]        r_status, n_status;

    logic              r_ring, n_ring;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [K_W-1:0]    r_k, n_k;

    logic [DUR_W-1:0]  r_mem [NSUB];
    logic [DUR_W-1:0]  r_rd_data;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [DUR_W-1:0]  mem_wdata;

    logic [POS_W-1:0]  occ [2];
    logic              start, scan_end, alloc_fit, slot_last, k_last, cur_run;
    logic [SUM_W-1:0]  alloc_sum;
    logic [IDX_W-1:0]  alloc_idx;
    logic [SLOT_W-1:0] alloc_slot, ld_slot, rc_slot;
    logic              ld_ring, ld_full, ld_many, rc_step;
    logic [PROC_W-1:0] cfg_v;

    function automatic logic [SLOT_W-1:0] slot_of(input logic ring,
                                                  input logic [IDX_W-1:0] idx);
        return (ring ? SLOT_W'(TASK_SLOTS) : '0) + SLOT_W'(idx);
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [SLOT_W-1:0] slot,
                                                  input logic [K_W-1:0] k);
        return ADDR_W'(slot) * ADDR_W'(MAX_SUBTASKS) + ADDR_W'(k);
    endfunction

    // Ring occupancy: the wrap bits tell whether the tail has lapped the head.
    always_comb begin
        for (int r = 0; r < 2; r++) begin
            occ[r] = POS_W'(r_tail_idx[r])
                   + ((r_tail_wrap[r] != r_head_wrap[r]) ? POS_W'(TASK_SLOTS) : '0)
                   - POS_W'(r_head_idx[r]);
        end
    end

    assign start      = (r_state == S_IDLE) && !i_cmd_empty && !i_res_full;
    assign scan_end   = (r_pos >= occ[r_ring]);
    assign alloc_sum  = SUM_W'(r_head_idx[r_ring]) + SUM_W'(r_pos);
    assign alloc_idx  = (alloc_sum >= SUM_W'(TASK_SLOTS))
                      ? IDX_W'(alloc_sum - SUM_W'(TASK_SLOTS)) : IDX_W'(alloc_sum);
    assign alloc_slot = slot_of(r_ring, alloc_idx);
    assign alloc_fit  = r_valid[alloc_slot] && !r_started[alloc_slot]
                      && (PROC_W'(r_cnt[alloc_slot]) <= r_free);

    assign ld_ring = (r_load_idx == '0) ? r_cmd.pri : r_load_pri;
    assign ld_full = (occ[ld_ring] == POS_W'(TASK_SLOTS));
    assign ld_many = (r_load_idx >= CNT_W'(MAX_SUBTASKS));
    assign ld_slot = slot_of(ld_ring, r_tail_idx[ld_ring]);

    assign slot_last = (r_slot == SLOT_W'(NS - 1));
    assign cur_run   = r_started[r_slot] && (r_done[r_slot] < r_cnt[r_slot]);
    assign k_last    = ((CNT_W'(r_k) + CNT_W'(1)) == r_cnt[r_slot]);

    assign rc_slot = slot_of(r_ring, r_head_idx[r_ring]);
    assign rc_step = !((r_head_idx[r_ring] == r_tail_idx[r_ring])
                       && (r_head_wrap[r_ring] == r_tail_wrap[r_ring]))
                   && !r_valid[rc_slot];

    always_comb begin
        cfg_v = i_cfg_data;
        if (cfg_v == '0) begin
            cfg_v = PROC_W'(1);
        end else if (cfg_v > PROC_W'(MAX_PROCESSORS)) begin
            cfg_v = PROC_W'(MAX_PROCESSORS);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = (i_cmd.kind == K_TICK) ? S_ALLOC : S_LOAD;
                end
            end
            S_LOAD: n_state = S_FINISH;
            S_ALLOC: begin
                if (scan_end && r_ring) begin
                    n_state = S_SLOT_CHK;
                end
            end
            S_SLOT_CHK: begin
                if (!r_valid[r_slot]) begin
                    n_state = slot_last ? S_RECLAIM : S_SLOT_CHK;
                end else if (cur_run) begin
                    n_state = S_SUB_RD;
                end else begin
                    n_state = S_SLOT_END;
                end
            end
            S_SUB_RD: n_state = S_SUB_WR;
            S_SUB_WR: n_state = k_last ? S_SLOT_END : S_SUB_RD;
            S_SLOT_END: n_state = slot_last ? S_RECLAIM : S_SLOT_CHK;
            S_RECLAIM: begin
                if (!rc_step && r_ring) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_cmd       = r_cmd;
        n_valid     = r_valid;
        n_started   = r_started;
        n_cnt       = r_cnt;
        n_done      = r_done;
        n_res       = r_res;
        n_svc       = r_svc;
        n_head_idx  = r_head_idx;
        n_head_wrap = r_head_wrap;
        n_tail_idx  = r_tail_idx;
        n_tail_wrap = r_tail_wrap;
        n_free      = r_free;
        n_pool      = r_pool;
        n_busy      = r_busy;
        n_load_idx  = r_load_idx;
        n_load_pri  = r_load_pri;
        n_max       = r_max;
        n_rres      = r_rres;
        n_rsvc      = r_rsvc;
        n_present   = r_present;
        n_pres_snap = r_pres_snap;
        n_rcount    = r_rcount;
        n_status    = r_status;
        n_ring      = r_ring;
        n_pos       = r_pos;
        n_slot      = r_slot;
        n_k         = r_k;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = addr_of(r_slot, r_k);
        mem_raddr   = addr_of(r_slot, r_k);
        mem_wdata   = r_rd_data - DUR_W'(1);
        o_cmd_pop   = 1'b0;
        o_res_push  = 1'b0;

        o_result.status               = (r_cmd.kind == K_TICK) ? ST_OK : r_status;
        o_result.busy_processors      = r_busy;
        o_result.tasks_present        = 6'((r_cmd.kind == K_TICK) ? r_pres_snap : r_present);
        o_result.retired_count        = 6'(r_rcount);
        o_result.retired_resident_sum = r_rres;
        o_result.retired_service_sum  = r_rsvc;
        o_result.max_service          = r_max;

        // The pool size only changes while no processor is handed out.
        if (i_cfg_valid && (r_free == r_pool)) begin
            n_pool = cfg_v;
            n_free = cfg_v;
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd_pop   = 1'b1;
                    n_cmd       = i_cmd;
                    n_ring      = 1'b0;
                    n_pos       = '0;
                    n_pres_snap = r_present;
                    n_rcount    = '0;
                    n_rres      = '0;
                    n_rsvc      = '0;
                end
            end
            S_LOAD: begin
                n_busy = r_pool - r_free;
                if (ld_full) begin
                    n_status   = ST_RING_FULL;
                    n_load_idx = '0;
                end else if (ld_many) begin
                    n_status   = ST_TOO_MANY;
                    n_load_idx = '0;
                end else if (r_cmd.zero_dur) begin
                    n_status   = ST_ZERO_DUR;
                    n_load_idx = '0;
                end else begin
                    n_status   = ST_OK;
                    mem_we     = 1'b1;
                    mem_waddr  = addr_of(ld_slot, r_load_idx[K_W-1:0]);
                    mem_wdata  = r_cmd.dur;
                    n_load_pri = ld_ring;
                    n_load_idx = r_load_idx + CNT_W'(1);
                    if (r_cmd.last) begin
                        n_valid[ld_slot]   = 1'b1;
                        n_started[ld_slot] = 1'b0;
                        n_cnt[ld_slot]     = r_load_idx + CNT_W'(1);
                        n_done[ld_slot]    = '0;
                        n_res[ld_slot]     = '0;
                        n_svc[ld_slot]     = '0;
                        if (r_tail_idx[ld_ring] == IDX_W'(TASK_SLOTS - 1)) begin
                            n_tail_idx[ld_ring]  = '0;
                            n_tail_wrap[ld_ring] = !r_tail_wrap[ld_ring];
                        end else begin
                            n_tail_idx[ld_ring] = r_tail_idx[ld_ring] + IDX_W'(1);
                        end
                        n_present  = r_present + PRES_W'(1);
                        n_load_idx = '0;
                    end
                end
            end
            S_ALLOC: begin
                if (!scan_end) begin
                    if (alloc_fit) begin
                        n_started[alloc_slot] = 1'b1;
                        n_free = r_free - PROC_W'(r_cnt[alloc_slot]);
                    end
                    n_pos = r_pos + POS_W'(1);
                end else if (!r_ring) begin
                    n_ring = 1'b1;
                    n_pos  = '0;
                end else begin
                    n_busy = r_pool - r_free;
                    n_slot = '0;
                end
            end
            S_SLOT_CHK: begin
                if (r_valid[r_slot]) begin
                    if (cur_run) begin
                        n_svc[r_slot] = sat_inc(r_svc[r_slot]);
                        n_k = '0;
                    end
                end else if (slot_last) begin
                    n_ring = 1'b0;
                end else begin
                    n_slot = r_slot + SLOT_W'(1);
                end
            end
            S_SUB_RD: begin
                mem_re = 1'b1;
            end
            S_SUB_WR: begin
                // A stored zero marks a subtask that has already finished.
                if (r_rd_data != '0) begin
                    mem_we = 1'b1;
                    if (r_rd_data == DUR_W'(1)) begin
                        n_done[r_slot] = r_done[r_slot] + CNT_W'(1);
                        n_free = r_free + PROC_W'(1);
                    end
                end
                n_k = r_k + K_W'(1);
            end
            S_SLOT_END: begin
                if (r_done[r_slot] >= r_cnt[r_slot]) begin
                    n_rcount       = r_rcount + PRES_W'(1);
                    n_rres         = sat_add(r_rres, r_res[r_slot]);
                    n_rsvc         = sat_add(r_rsvc, r_svc[r_slot]);
                    n_max          = (r_svc[r_slot] > r_max) ? r_svc[r_slot] : r_max;
                    n_valid[r_slot] = 1'b0;
                    n_present      = r_present - PRES_W'(1);
                end else begin
                    n_res[r_slot] = sat_inc(r_res[r_slot]);
                end
                if (slot_last) begin
                    n_ring = 1'b0;
                end else begin
                    n_slot = r_slot + SLOT_W'(1);
                end
            end
            S_RECLAIM: begin
                if (rc_step) begin
                    if (r_head_idx[r_ring] == IDX_W'(TASK_SLOTS - 1)) begin
                        n_head_idx[r_ring]  = '0;
                        n_head_wrap[r_ring] = !r_head_wrap[r_ring];
                    end else begin
                        n_head_idx[r_ring] = r_head_idx[r_ring] + IDX_W'(1);
                    end
                end else if (!r_ring) begin
                    n_ring = 1'b1;
                end
            end
            S_FINISH: begin
                o_res_push = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_started   <= '0;
            r_head_idx  <= '{default: '0};
            r_tail_idx  <= '{default: '0};
            r_head_wrap <= '0;
            r_tail_wrap <= '0;
            r_free      <= PROC_W'(MAX_PROCESSORS);
            r_pool      <= PROC_W'(MAX_PROCESSORS);
            r_load_idx  <= '0;
            r_load_pri  <= 1'b0;
            r_max       <= '0;
            r_present   <= '0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_started   <= n_started;
            r_head_idx  <= n_head_idx;
            r_tail_idx  <= n_tail_idx;
            r_head_wrap <= n_head_wrap;
            r_tail_wrap <= n_tail_wrap;
            r_free      <= n_free;
            r_pool      <= n_pool;
            r_load_idx  <= n_load_idx;
            r_load_pri  <= n_load_pri;
            r_max       <= n_max;
            r_present   <= n_present;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_cnt       <= n_cnt;
        r_done      <= n_done;
        r_res       <= n_res;
        r_svc       <= n_svc;
        r_busy      <= n_busy;
        r_rres      <= n_rres;
        r_rsvc      <= n_rsvc;
        r_pres_snap <= n_pres_snap;
        r_rcount    <= n_rcount;
        r_status    <= n_status;
        r_ring      <= n_ring;
        r_pos       <= n_pos;
        r_slot      <= n_slot;
        r_k         <= n_k;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/gang_task_dispatcher.sv
// Top level of the gang task dispatcher: front queue, back end and result queue.
//
//  channel   direction  handshake                 word
//  input     in         push / full               i_item (t_item)
//  result    out        pop / empty               o_result (t_result)
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_data (pool size)
//
// A load word passes the back end in three steps (start, load, finish).
// A tick scans the occupied positions of both rings to start tasks that fit the free
// processors, checks all 2*TASK_SLOTS slots, reads and writes back each subtask of
// every running task in the subtask memory, then reclaims retired head slots of both
// rings and finishes.
// Reset clears the task valid and started bits, the ring pointers, the processor pool
// and the load state; the subtask memory needs no clearing. A command queue of two
// words takes input while the back end works, and a result queue of two words holds results until popped.
`timescale 1ns / 1ps
`default_nettype none

module gang_task_dispatcher
    import gtd_pkg::*;
#(
    parameter int TASK_SLOTS     = DEF_TASK_SLOTS,
    parameter int MAX_SUBTASKS   = DEF_MAX_SUBTASKS,
    parameter int MAX_PROCESSORS = DEF_MAX_PROCESSORS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    input  wire t_item             i_item,
    output logic                   full,
    input  wire logic              pop,
    output t_result                o_result,
    output logic                   empty,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [PROC_W-1:0] i_cfg_data
);

    t_cmd                       cmd;
    logic                       cmd_empty, cmd_pop;
    logic                       res_full, res_push;
    t_result                    res_word;
    logic [$bits(t_result)-1:0] res_bits;

    assign o_cfg_ready = 1'b1;

    gtd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd),
        .o_cmd_empty (cmd_empty)
    );

    gtd_back #(
        .TASK_SLOTS     (TASK_SLOTS),
        .MAX_SUBTASKS   (MAX_SUBTASKS),
        .MAX_PROCESSORS (MAX_PROCESSORS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_result    (res_word)
    );

    gtd_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_word),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_bits),
        .o_empty (empty)
    );

    assign o_result = t_result'(res_bits);

    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result written into a full result queue");

    a_cmd_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command taken from an empty command queue");

    a_pop_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |=> !res_push)
        else $error("result written in the cycle after a command was taken");

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result.status != ST_OK)) |-> (o_result.retired_count == 6'd0))
        else $error("rejected load word reports retired tasks");

    a_busy_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.busy_processors <= PROC_W'(MAX_PROCESSORS)))
        else $error("busy processor count beyond the pool");

endmodule

`default_nettype wire
